// File: hdl/sha256_pkg.sv
// shared types, constants and sigma functions for the sha-256 stream hasher
package sha256_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0][31:0] vec8_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_FOLD,
      ST_PAD,
      ST_LENGTH,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_PAD,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         req_ready;
      logic         rsp_valid;
      logic         byte_en;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         count_inc;
      logic         len_capture;
      logic         work_load;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         fold;
      logic         hash_init;
      logic [2:0]   word_idx;
   } ctrl_type;

   // input beat action codes
   localparam logic ACTION_ABSORB = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_PAD_END = 6'd55;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] IDX_LAST = 3'd7;

   localparam vec8_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

// File: hdl/sha256_round.sv
// one sha-256 compression round, shared across all 64 rounds
module sha256_round (
   input  sha256_pkg::vec8_type  work_in,
   input  sha256_pkg::word_type  k_in,
   input  sha256_pkg::word_type  w_in,
   output sha256_pkg::vec8_type  work_out
);

   sha256_pkg::word_type ch;
   sha256_pkg::word_type mj;
   sha256_pkg::word_type x1;
   sha256_pkg::word_type x2;

   always_comb begin
      ch = (work_in[4] & work_in[5]) ^ (~work_in[4] & work_in[6]);
      mj = (work_in[0] & work_in[1]) ^ (work_in[0] & work_in[2]) ^ (work_in[1] & work_in[2]);
      x1 = work_in[7] + sha256_pkg::big_sigma1(work_in[4]) + ch + k_in + w_in;
      x2 = sha256_pkg::big_sigma0(work_in[0]) + mj;
      work_out[7] = work_in[6];
      work_out[6] = work_in[5];
      work_out[5] = work_in[4];
      work_out[4] = work_in[3] + x1;
      work_out[3] = work_in[2];
      work_out[2] = work_in[1];
      work_out[1] = work_in[0];
      work_out[0] = x1 + x2;
   end

endmodule

// File: hdl/sha256_sched.sv
// 16-word message window: byte-wise fill, then word-wise schedule expansion
module sha256_sched (
   input  logic                 clock,
   input  logic                 byte_en,
   input  logic [7:0]           byte_in,
   input  logic                 step_en,
   output sha256_pkg::word_type w_out
);

   sha256_pkg::word_type w_ff [16];
   sha256_pkg::word_type w_in [16];
   sha256_pkg::word_type w_new;

   always_comb begin
      w_new = sha256_pkg::small_sigma1(w_ff[14]) + w_ff[9] +
              sha256_pkg::small_sigma0(w_ff[1]) + w_ff[0];
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end
      if (byte_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i + 1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], byte_in};
      end else if (step_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = w_new;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign w_out = w_ff[0];

endmodule

// File: hdl/sha256_fsm.sv
// sequencer: absorb, padding, length, 64 rounds, fold and digest emission
module sha256_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   input  logic                 rsp_ready,
   input  logic [5:0]           fill,
   output sha256_pkg::ctrl_type ctrl
);

   sha256_pkg::state_type state_ff, state_in;
   sha256_pkg::state_type ret_ff, ret_in;
   logic [5:0] round_ff, round_in;
   logic [5:0] pos_ff, pos_in;
   logic       first_ff, first_in;
   logic [2:0] lidx_ff, lidx_in;
   logic [2:0] widx_ff, widx_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && (state_ff == sha256_pkg::ST_IDLE);
   assign rsp_fire = rsp_ready && (state_ff == sha256_pkg::ST_EMIT);

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_action == sha256_pkg::ACTION_FINISH) begin
                  state_in = sha256_pkg::ST_PAD;
               end else if (fill == sha256_pkg::FILL_LAST) begin
                  state_in = sha256_pkg::ST_COMPRESS;
                  ret_in = sha256_pkg::ST_IDLE;
               end
            end
         end
         sha256_pkg::ST_COMPRESS: begin
            if (round_ff == sha256_pkg::ROUND_LAST) begin
               state_in = sha256_pkg::ST_FOLD;
            end
         end
         sha256_pkg::ST_FOLD: begin
            state_in = ret_ff;
         end
         sha256_pkg::ST_PAD: begin
            if (pos_ff == sha256_pkg::FILL_LAST) begin
               state_in = sha256_pkg::ST_COMPRESS;
               ret_in = sha256_pkg::ST_PAD;
            end else if (pos_ff == sha256_pkg::FILL_PAD_END) begin
               state_in = sha256_pkg::ST_LENGTH;
            end
         end
         sha256_pkg::ST_LENGTH: begin
            if (lidx_ff == sha256_pkg::IDX_LAST) begin
               state_in = sha256_pkg::ST_COMPRESS;
               ret_in = sha256_pkg::ST_EMIT;
            end
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_fire && (widx_ff == sha256_pkg::IDX_LAST)) begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

   // counters
   always_comb begin
      round_in = (state_ff == sha256_pkg::ST_COMPRESS) ? round_ff + 6'd1 : '0;
      lidx_in = (state_ff == sha256_pkg::ST_LENGTH) ? lidx_ff + 3'd1 : '0;
      widx_in = widx_ff;
      if (state_ff != sha256_pkg::ST_EMIT) begin
         widx_in = '0;
      end else if (rsp_fire) begin
         widx_in = widx_ff + 3'd1;
      end
      pos_in = pos_ff;
      first_in = first_ff;
      if (req_fire && (req_action == sha256_pkg::ACTION_FINISH)) begin
         pos_in = fill;
         first_in = 1'b1;
      end else if (state_ff == sha256_pkg::ST_PAD) begin
         pos_in = pos_ff + 6'd1;
         first_in = 1'b0;
      end
   end

   // outputs
   always_comb begin
      ctrl = '0;
      ctrl.byte_sel = sha256_pkg::SEL_DATA;
      ctrl.len_idx = lidx_ff;
      ctrl.round_idx = round_ff;
      ctrl.word_idx = widx_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            if (req_fire) begin
               if (req_action == sha256_pkg::ACTION_FINISH) begin
                  ctrl.len_capture = 1'b1;
               end else begin
                  ctrl.byte_en = 1'b1;
                  ctrl.count_inc = 1'b1;
                  ctrl.work_load = (fill == sha256_pkg::FILL_LAST);
               end
            end
         end
         sha256_pkg::ST_COMPRESS: begin
            ctrl.round_en = 1'b1;
         end
         sha256_pkg::ST_FOLD: begin
            ctrl.fold = 1'b1;
         end
         sha256_pkg::ST_PAD: begin
            ctrl.byte_en = 1'b1;
            ctrl.byte_sel = first_ff ? sha256_pkg::SEL_PAD : sha256_pkg::SEL_ZERO;
            ctrl.work_load = (pos_ff == sha256_pkg::FILL_LAST);
         end
         sha256_pkg::ST_LENGTH: begin
            ctrl.byte_en = 1'b1;
            ctrl.byte_sel = sha256_pkg::SEL_LEN;
            ctrl.work_load = (lidx_ff == sha256_pkg::IDX_LAST);
         end
         sha256_pkg::ST_EMIT: begin
            ctrl.rsp_valid = 1'b1;
            ctrl.hash_init = rsp_fire && (widx_ff == sha256_pkg::IDX_LAST);
         end
         default: begin
            ctrl.req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         ret_ff <= sha256_pkg::ST_IDLE;
         round_ff <= '0;
         pos_ff <= '0;
         first_ff <= 1'b0;
         lidx_ff <= '0;
         widx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         round_ff <= round_in;
         pos_ff <= pos_in;
         first_ff <= first_in;
         lidx_ff <= lidx_in;
         widx_ff <= widx_in;
      end
   end

endmodule

// File: hdl/sha256_stream_hasher_core.sv
// sha-256 byte-stream hasher top level: chaining state, counters and stream ports
// absorb beat: one byte; one that completes a block also runs the rounds and the fold
// finish beat: pad marker, zeros to byte 55 and 8 length bytes, then rounds and fold;
//   with fill 56 or more, padding first fills, compresses and folds an extra block
// then 8 digest beats, one per ready cycle; the single round unit does one round per cycle
// reset loads the initial hash values, clears the byte count and returns to idle
// the block accepts no beat while compressing, folding, padding, sending the length or emitting the digest
module sha256_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] action: 0 absorb, 1 finish
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic        rsp_tlast    // last_word
);

   sha256_pkg::ctrl_type ctrl;

   // chaining state and working variables a..h (index 0 is a)
   sha256_pkg::vec8_type hash_ff, hash_in;
   sha256_pkg::vec8_type work_ff, work_in;
   sha256_pkg::vec8_type work_next;

   // byte count wraps modulo 2^61, so the bit length wraps modulo 2^64
   logic [60:0]     count_ff, count_in;
   logic [7:0][7:0] len_ff, len_in;

   logic [7:0]           shift_byte;
   sha256_pkg::word_type w_t;
   sha256_pkg::word_type k_t;

   sha256_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser[0]),
      .rsp_ready  (rsp_tready),
      .fill       (count_ff[5:0]),
      .ctrl       (ctrl)
   );

   // byte fed into the message window: data, padding marker, zero or length
   always_comb begin
      case (ctrl.byte_sel)
         sha256_pkg::SEL_DATA: shift_byte = req_tdata;
         sha256_pkg::SEL_PAD:  shift_byte = sha256_pkg::PAD_BYTE;
         sha256_pkg::SEL_ZERO: shift_byte = 8'h00;
         sha256_pkg::SEL_LEN:  shift_byte = len_ff[sha256_pkg::IDX_LAST - ctrl.len_idx];
         default:              shift_byte = 8'h00;
      endcase
   end

   sha256_sched u_sched (
      .clock   (clock),
      .byte_en (ctrl.byte_en),
      .byte_in (shift_byte),
      .step_en (ctrl.round_en),
      .w_out   (w_t)
   );

   assign k_t = sha256_pkg::ROUND_K[ctrl.round_idx];

   sha256_round u_round (
      .work_in  (work_ff),
      .k_in     (k_t),
      .w_in     (w_t),
      .work_out (work_next)
   );

   always_comb begin
      work_in = work_ff;
      if (ctrl.work_load) begin
         work_in = hash_ff;
      end else if (ctrl.round_en) begin
         work_in = work_next;
      end
   end

   // fold the finished rounds into the chaining state; re-init after the digest
   always_comb begin
      hash_in = hash_ff;
      if (ctrl.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end else if (ctrl.hash_init) begin
         hash_in = sha256_pkg::INIT_HASH;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.hash_init) begin
         count_in = '0;
      end else if (ctrl.count_inc) begin
         count_in = count_ff + 61'd1;
      end
      len_in = len_ff;
      if (ctrl.len_capture) begin
         len_in = {count_ff, 3'b000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= sha256_pkg::INIT_HASH;
         count_ff <= '0;
      end else begin
         hash_ff <= hash_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      len_ff <= len_in;
   end

   // digest words are read straight from the chaining state while emitting
   assign req_tready = ctrl.req_ready;
   assign rsp_tvalid = ctrl.rsp_valid;
   assign rsp_tdata = {5'b00000, ctrl.word_idx, hash_ff[ctrl.word_idx]};
   assign rsp_tlast = (ctrl.word_idx == sha256_pkg::IDX_LAST);

   // never both sides open at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while emitting digest");

   // a digest always starts at word zero
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (rsp_tdata[34:32] == 3'd0))
      else $error("digest does not start at word zero");

   // a byte that fills the block starts a compression
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser[0] == sha256_pkg::ACTION_ABSORB) &&
       (count_ff[5:0] == sha256_pkg::FILL_LAST))
      |=> (!req_tready && (count_ff[5:0] == 6'd0)))
      else $error("full block not compressed");

   // after the final digest word the block is idle with fresh state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast)
      |=> (req_tready && (count_ff == '0) && (hash_ff == sha256_pkg::INIT_HASH)))
      else $error("state not re-initialized after digest");

endmodule

// File: tb/sha256_digest_checker.sv
// stream monitor for the sha-256 hasher: predicts digest beats and compares them
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   input  logic        rsp_tlast,   // last_word
   output int          fault_count,
   output int          words_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         MAX_REPORTS = 10;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam int         LEN_FIELD_AT = 56;

   localparam sha256_pkg::word_type IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam sha256_pkg::word_type RK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      sha256_pkg::word_type word;
      logic [2:0]           pos;
      logic                 last;
   } digest_beat_type;

   sha256_pkg::word_type chain_h [8];
   logic [7:0]           blk [64];
   logic [60:0]          msg_bytes;
   digest_beat_type      digest_q [$];
   int                   errors = 0;

   function automatic sha256_pkg::word_type ror32(input sha256_pkg::word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_chain();
      for (int i = 0; i < 8; i++)
         chain_h[i] = IV_WORDS[i];
      msg_bytes = '0;
   endfunction

   function automatic void crunch_block();
      sha256_pkg::word_type sched [64];
      sha256_pkg::word_type v [8];
      sha256_pkg::word_type s0, s1, ch, mj, t1, t2;
      for (int t = 0; t < 16; t++)
         sched[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
      end
      for (int i = 0; i < 8; i++)
         v[i] = chain_h[i];
      for (int t = 0; t < 64; t++) begin
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch + RK[t]
            + sched[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain_h[i] = chain_h[i] + v[i];
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      int fill;
      fill = int'(msg_bytes[5:0]);
      blk[fill] = b;
      msg_bytes = msg_bytes + 61'd1;
      if (fill == 63)
         crunch_block();
   endfunction

   // pad, append the bit length and queue the eight digest words
   function automatic void close_message();
      logic [63:0]     bit_len;
      int              fill;
      digest_beat_type beat;
      bit_len = {msg_bytes, 3'b000};
      fill = int'(msg_bytes[5:0]);
      blk[fill] = PAD_MARK;
      fill++;
      // no room left for the length: spill into an extra block
      if (fill > LEN_FIELD_AT) begin
         while (fill < 64) begin
            blk[fill] = 8'h00;
            fill++;
         end
         crunch_block();
         fill = 0;
      end
      while (fill < LEN_FIELD_AT) begin
         blk[fill] = 8'h00;
         fill++;
      end
      for (int k = 0; k < 8; k++)
         blk[63-k] = bit_len[8*k +: 8];
      crunch_block();
      for (int k = 0; k < 8; k++) begin
         beat.word = chain_h[k];
         beat.pos = 3'(k);
         beat.last = (k == 7);
         digest_q.push_back(beat);
      end
      restart_chain();
   endfunction

   always @(posedge clock) begin
      digest_beat_type seen;
      digest_beat_type want;
      if (reset) begin
         restart_chain();
         digest_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast};
            if (digest_q.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected digest beat: word %h index %0d last %b",
                           seen.word, seen.pos, seen.last);
            end else begin
               want = digest_q.pop_front();
               if (seen.word !== want.word || seen.pos !== want.pos ||
                   seen.last !== want.last) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("digest mismatch: expected word %h index %0d last %b, got word %h index %0d last %b",
                              want.word, want.pos, want.last, seen.word, seen.pos, seen.last);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == sha256_pkg::ACTION_FINISH)
               close_message();
            else
               absorb_byte(req_tdata);
         end
      end
      fault_count <= errors;
      words_owed <= digest_q.size();
   end

endmodule

// File: tb/sha256_stream_hasher_core_tb.sv
// top of the sha-256 hasher testbench: clock, reset, message stimulus and verdict
module sha256_stream_hasher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   RESET_CYCLES = 6;
   localparam int   HOLD_CYCLES = 400;     // long receiver hold-off right after reset
   localparam int   RANDOM_ITEMS = 130;
   localparam int   QUIET_AFTER = 100;     // random beats before idling stops
   localparam int   SETTLE_CYCLES = 250;   // covers a finish with an extra block
   localparam int   CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic [0:0]  req_tuser = '0;    // [0] action: 0 absorb, 1 finish
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] digest_word, [34:32] word_index, [39:35] zero
   logic        rsp_tlast;         // last_word

   int   fault_count;
   int   words_owed;
   int   cycle_count = 0;
   int   beats_sent = 0;
   int   quiet_mark = 32'h7fffffff;
   logic steady = 1'b0;            // set for the last part of the run: no idling

   sha256_stream_hasher_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sha256_digest_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .fault_count (fault_count),
      .words_owed  (words_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // offer one beat, maybe after a random idle burst, and hold it until accepted
   task automatic send_beat(input logic act, input logic [7:0] b);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (beats_sent >= quiet_mark)
         steady <= 1'b1;
   endtask

   // random message body of the given length, then a finish beat with junk data
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_beat(sha256_pkg::ACTION_ABSORB, 8'($urandom_range(0, 255)));
      send_beat(sha256_pkg::ACTION_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // receiver: one long hold-off so the block waits on its digest and stalls its input,
   // then random ready gaps until the quiet tail
   initial begin
      while (reset) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
      forever begin
         if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("sha256_stream_hasher_core test failed");
      $finish;
   end

   initial begin
      int msg_no;
      int random_start;
      int len;
      int room;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty message, data on the finish beat must be ignored
      send_beat(sha256_pkg::ACTION_FINISH, 8'ha5);
      // single-byte messages at both byte extremes
      send_beat(sha256_pkg::ACTION_ABSORB, 8'h00);
      send_beat(sha256_pkg::ACTION_FINISH, 8'hff);
      send_beat(sha256_pkg::ACTION_ABSORB, 8'hff);
      send_beat(sha256_pkg::ACTION_FINISH, 8'h00);
      // the classic three-byte message
      send_beat(sha256_pkg::ACTION_ABSORB, 8'h61);
      send_beat(sha256_pkg::ACTION_ABSORB, 8'h62);
      send_beat(sha256_pkg::ACTION_ABSORB, 8'h63);
      send_beat(sha256_pkg::ACTION_FINISH, 8'h5a);

      // random messages: the first leaves no room for the length field (extra block),
      // the second fills a block exactly so the finish starts on an empty buffer
      random_start = beats_sent;
      quiet_mark = random_start + QUIET_AFTER;
      msg_no = 0;
      while (beats_sent - random_start < RANDOM_ITEMS) begin
         room = RANDOM_ITEMS - (beats_sent - random_start) - 1;
         if (msg_no == 0)
            len = $urandom_range(56, 63);
         else if (msg_no == 1)
            len = 64;
         else if ($urandom_range(0, 4) == 0)
            len = $urandom_range(40, 70);
         else
            len = $urandom_range(0, 12);
         // keep the run near its beat budget
         if (msg_no > 1 && len > room)
            len = room;
         send_message(len);
         msg_no++;
      end
      req_tvalid <= 1'b0;

      // drain outstanding digest beats, then let the block settle
      do @(posedge clock); while (words_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("sha256_stream_hasher_core test passed");
      else
         $display("sha256_stream_hasher_core test failed");
      $finish;
   end

endmodule

// File: filelist.f
hdl/sha256_pkg.sv
hdl/sha256_round.sv
hdl/sha256_sched.sv
hdl/sha256_fsm.sv
hdl/sha256_stream_hasher_core.sv
tb/sha256_digest_checker.sv
tb/sha256_stream_hasher_core_tb.sv
